/* rtl/keyboard_scan_code_processor_defines.svh */
// assertion macros shared by the keyboard scan code processor modules
`ifndef KEYBOARD_SCAN_CODE_PROCESSOR_DEFINES_SVH
`define KEYBOARD_SCAN_CODE_PROCESSOR_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define KSC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyboard scan code processor check failed");

// condition must hold in the cycle after the trigger
`define KSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyboard scan code processor check failed");

`endif

/* rtl/ksc_pkg.sv */
// types, constants and translation tables of the keyboard scan code processor
`timescale 1ns / 1ps
package ksc_pkg;

  // sizes
  localparam int QUEUE_DEPTH = 64;
  localparam int TICK_BITS   = 32;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = QIDX_W + 1;

  // configuration space
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] CFG_IDX_REPEAT_WINDOW = '0;
  localparam logic [7:0] REPEAT_WINDOW_RST = 8'd1;

  // transaction function codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // keyboard bytes
  localparam logic [7:0] CODE_ACK    = 8'hFA;
  localparam logic [7:0] CODE_RESEND = 8'hFE;
  localparam logic [7:0] CODE_PFX_E0 = 8'hE0;
  localparam logic [7:0] CODE_PFX_E1 = 8'hE1;

  // scan codes with modifier meaning
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_ALT    = 7'h38;
  localparam logic [6:0] SC_CAPS   = 7'h3A;
  localparam logic [6:0] SC_NUM    = 7'h45;
  localparam logic [6:0] SC_SCROLL = 7'h46;

  // modifier flag bit positions
  localparam int MOD_SHIFT  = 0;
  localparam int MOD_CTRL   = 1;
  localparam int MOD_ALT    = 2;
  localparam int MOD_CAPS   = 3;
  localparam int MOD_NUM    = 4;
  localparam int MOD_SCROLL = 5;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_POP   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef logic [QIDX_W-1:0] qidx_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  key_byte;
    logic [31:0] tick_now;
    logic        expecting_reply;
  } ksc_item_t;

  typedef struct packed {
    kind_t       result_kind;
    logic        reply_is_resend;
    logic        key_accepted;
    logic        key_dropped;
    logic [6:0]  scan_code;
    logic [6:0]  ascii_code;
    logic [5:0]  modifier_flags;
    logic [2:0]  led_mask;
    logic [5:0]  queue_count;
  } ksc_result_t;

  // ring index step
  function automatic qidx_t next_idx(qidx_t i);
    qidx_t r;
    if (i == qidx_t'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  // {shifted, plain} character for a set 1 scan code
  function automatic logic [13:0] xlat_pair(logic [6:0] scan);
    logic [13:0] r;
    case (scan)
      7'h01: r = {7'h1B, 7'h1B};
      7'h02: r = {7'h21, 7'h31};
      7'h03: r = {7'h40, 7'h32};
      7'h04: r = {7'h23, 7'h33};
      7'h05: r = {7'h24, 7'h34};
      7'h06: r = {7'h25, 7'h35};
      7'h07: r = {7'h5E, 7'h36};
      7'h08: r = {7'h26, 7'h37};
      7'h09: r = {7'h2A, 7'h38};
      7'h0A: r = {7'h28, 7'h39};
      7'h0B: r = {7'h29, 7'h30};
      7'h0C: r = {7'h5F, 7'h2D};
      7'h0D: r = {7'h2B, 7'h3D};
      7'h0E: r = {7'h08, 7'h08};
      7'h0F: r = {7'h09, 7'h09};
      7'h10: r = {7'h51, 7'h71};
      7'h11: r = {7'h57, 7'h77};
      7'h12: r = {7'h45, 7'h65};
      7'h13: r = {7'h52, 7'h72};
      7'h14: r = {7'h54, 7'h74};
      7'h15: r = {7'h59, 7'h79};
      7'h16: r = {7'h55, 7'h75};
      7'h17: r = {7'h49, 7'h69};
      7'h18: r = {7'h4F, 7'h6F};
      7'h19: r = {7'h50, 7'h70};
      7'h1A: r = {7'h7B, 7'h5B};
      7'h1B: r = {7'h7D, 7'h5D};
      7'h1C: r = {7'h0D, 7'h0D};
      7'h1E: r = {7'h41, 7'h61};
      7'h1F: r = {7'h53, 7'h73};
      7'h20: r = {7'h44, 7'h64};
      7'h21: r = {7'h46, 7'h66};
      7'h22: r = {7'h47, 7'h67};
      7'h23: r = {7'h48, 7'h68};
      7'h24: r = {7'h4A, 7'h6A};
      7'h25: r = {7'h4B, 7'h6B};
      7'h26: r = {7'h4C, 7'h6C};
      7'h27: r = {7'h3A, 7'h3B};
      7'h28: r = {7'h22, 7'h27};
      7'h29: r = {7'h7E, 7'h60};
      7'h2B: r = {7'h7C, 7'h5C};
      7'h2C: r = {7'h5A, 7'h7A};
      7'h2D: r = {7'h58, 7'h78};
      7'h2E: r = {7'h43, 7'h63};
      7'h2F: r = {7'h56, 7'h76};
      7'h30: r = {7'h42, 7'h62};
      7'h31: r = {7'h4E, 7'h6E};
      7'h32: r = {7'h4D, 7'h6D};
      7'h33: r = {7'h3C, 7'h2C};
      7'h34: r = {7'h3E, 7'h2E};
      7'h35: r = {7'h3F, 7'h2F};
      7'h39: r = {7'h20, 7'h20};
      default: r = '0;
    endcase
    return r;
  endfunction

  // letters follow shift xor caps, everything else follows shift alone
  function automatic logic [6:0] to_ascii(logic [6:0] scan, logic shift, logic caps);
    logic [13:0] pair;
    logic [6:0]  plain;
    logic [6:0]  shifted;
    logic        letter;
    pair    = xlat_pair(scan);
    plain   = pair[6:0];
    shifted = pair[13:7];
    letter  = (plain >= 7'h61) && (plain <= 7'h7A);
    if (letter) begin
      return (shift ^ caps) ? shifted : plain;
    end
    return shift ? shifted : plain;
  endfunction

endpackage

/* rtl/ksc_if.sv */
// valid/ready channel interfaces for keyboard transactions and results
`timescale 1ns / 1ps
interface ksc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  key_byte;
  logic [31:0] tick_now;
  logic        expecting_reply;

  modport source (output valid, output func, output key_byte, output tick_now,
                  output expecting_reply, input ready);
  modport sink   (input valid, input func, input key_byte, input tick_now,
                  input expecting_reply, output ready);
endinterface

interface ksc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic        reply_is_resend;
  logic        key_accepted;
  logic        key_dropped;
  logic [6:0]  scan_code;
  logic [6:0]  ascii_code;
  logic [5:0]  modifier_flags;
  logic [2:0]  led_mask;
  logic [5:0]  queue_count;

  modport source (output valid, output result_kind, output reply_is_resend,
                  output key_accepted, output key_dropped, output scan_code,
                  output ascii_code, output modifier_flags, output led_mask,
                  output queue_count, input ready);
  modport sink   (input valid, input result_kind, input reply_is_resend,
                  input key_accepted, input key_dropped, input scan_code,
                  input ascii_code, input modifier_flags, input led_mask,
                  input queue_count, output ready);
endinterface

/* rtl/ksc_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ksc_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ksc_core.sv */
// scan code decode, modifier tracking, repeat filter and key queue
`timescale 1ns / 1ps
`include "keyboard_scan_code_processor_defines.svh"
module ksc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_accept,
  input  ksc_pkg::ksc_item_t  item,
  input  logic [7:0]          repeat_window,
  output ksc_pkg::ksc_result_t result
);
  import ksc_pkg::*;

  logic [5:0]           mod_r, mod_nxt;
  logic                 prefix_r, prefix_nxt;
  logic [6:0]           last_scan_r, last_scan_nxt;
  logic [TICK_BITS-1:0] last_time_r, last_time_nxt;
  qidx_t                rd_idx_r, rd_idx_nxt;
  qidx_t                wr_idx_r, wr_idx_nxt;
  logic                 byp_v_r, byp_v_nxt;
  logic [6:0]           byp_d_r;

  logic [TICK_BITS-1:0] now;
  logic [TICK_BITS-1:0] elapsed;
  logic                 q_empty;
  qidx_t                wr_next;
  logic [6:0]           ram_q;
  logic [6:0]           head;
  logic                 wr_en;
  logic                 brk;
  logic [6:0]           low;
  logic [CNT_W-1:0]     cnt;
  logic                 pop_empty;

  // queue storage, read address follows the next head so data is ready in time
  ksc_ram #(.WIDTH(7), .DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx_r),
    .wdata (item.key_byte[6:0]),
    .raddr (rd_idx_nxt),
    .rdata (ram_q)
  );

  assign now       = TICK_BITS'(item.tick_now);
  assign elapsed   = now - last_time_r;
  assign q_empty   = (rd_idx_r == wr_idx_r);
  assign wr_next   = next_idx(wr_idx_r);
  assign head      = byp_v_r ? byp_d_r : ram_q;
  assign brk       = item.key_byte[7];
  assign low       = item.key_byte[6:0];
  assign pop_empty = item_accept && item.func == FUNC_POP && q_empty;

  // per-transaction decode and state update
  always_comb begin
    mod_nxt       = mod_r;
    prefix_nxt    = prefix_r;
    last_scan_nxt = last_scan_r;
    last_time_nxt = last_time_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    wr_en         = 1'b0;
    result        = '0;
    result.result_kind = KIND_BYTE;

    if (item_accept) begin
      if (item.func == FUNC_POP) begin
        if (q_empty) begin
          result.result_kind = KIND_EMPTY;
        end else begin
          result.result_kind = KIND_POP;
          result.scan_code   = head;
          result.ascii_code  = to_ascii(head, mod_r[MOD_SHIFT], mod_r[MOD_CAPS]);
          rd_idx_nxt         = next_idx(rd_idx_r);
        end
      end else if (item.expecting_reply &&
                   (item.key_byte == CODE_ACK || item.key_byte == CODE_RESEND)) begin
        result.result_kind     = KIND_REPLY;
        result.reply_is_resend = (item.key_byte == CODE_RESEND);
      end else if (item.key_byte == CODE_PFX_E0 || item.key_byte == CODE_PFX_E1) begin
        prefix_nxt = 1'b1;
      end else begin
        // modifiers follow make and break, locks toggle on make
        case (low) inside
          SC_LSHIFT, SC_RSHIFT: mod_nxt[MOD_SHIFT] = !brk;
          SC_CTRL:              mod_nxt[MOD_CTRL]  = !brk;
          SC_ALT:               mod_nxt[MOD_ALT]   = !brk;
          SC_CAPS:   if (!brk) mod_nxt[MOD_CAPS]   = !mod_r[MOD_CAPS];
          SC_NUM:    if (!brk) mod_nxt[MOD_NUM]    = !mod_r[MOD_NUM];
          SC_SCROLL: if (!brk) mod_nxt[MOD_SCROLL] = !mod_r[MOD_SCROLL];
          default: ;
        endcase
        // unprefixed make codes pass the autorepeat filter into the queue
        if (!brk && !prefix_r) begin
          if (!(low == last_scan_r && elapsed <= TICK_BITS'(repeat_window))) begin
            last_scan_nxt = low;
            last_time_nxt = now;
            if (wr_next != rd_idx_r) begin
              wr_en               = 1'b1;
              wr_idx_nxt          = wr_next;
              result.key_accepted = 1'b1;
            end else begin
              result.key_dropped = 1'b1;
            end
          end
        end
        prefix_nxt = 1'b0;
      end
    end

    result.modifier_flags = mod_nxt;
    result.led_mask       = {mod_nxt[MOD_CAPS], mod_nxt[MOD_NUM], mod_nxt[MOD_SCROLL]};
    result.queue_count    = 6'(cnt);
  end

  // fill level after this transaction
  always_comb begin
    if (wr_idx_nxt >= rd_idx_nxt) begin
      cnt = CNT_W'(wr_idx_nxt) - CNT_W'(rd_idx_nxt);
    end else begin
      cnt = CNT_W'(wr_idx_nxt) + CNT_W'(QUEUE_DEPTH) - CNT_W'(rd_idx_nxt);
    end
  end

  // bypass a write that lands on the address being read this cycle
  assign byp_v_nxt = wr_en && (wr_idx_r == rd_idx_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= '0;
      prefix_r    <= 1'b0;
      last_scan_r <= '0;
      last_time_r <= '0;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      byp_v_r     <= 1'b0;
    end else begin
      mod_r       <= mod_nxt;
      prefix_r    <= prefix_nxt;
      last_scan_r <= last_scan_nxt;
      last_time_r <= last_time_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      byp_v_r     <= byp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_d_r <= item.key_byte[6:0];
  end

  // checks
  `KSC_ASSERT_NEXT(a_empty_pop_keeps_head, pop_empty, $stable(rd_idx_r))
  `KSC_ASSERT_NEXT(a_write_leaves_entry, wr_en, wr_idx_r != rd_idx_r)
  `KSC_ASSERT_SAME(a_bypass_only_nonempty, byp_v_r, wr_idx_r != rd_idx_r)

endmodule

/* rtl/keyboard_scan_code_processor.sv */
// top level: config register, core and two-entry result buffer
//
//   channel   direction  handshake          contents
//   in_ch     in         valid/ready        func, key_byte, tick_now, expecting_reply
//   out_ch    out        valid/ready        one result per transaction
//   cfg_*     in         apb write/read     repeat_window at byte address 0
//
// one transaction per cycle while in_ch.ready is high; its result is registered on accept
// queue read data comes from the store ram, prefetched at the next head index
// a two-entry output buffer keeps input open while one result waits
// in_ch.ready drops only when both result entries are full
// synchronous active-low reset clears state; repeat_window resets to 1
`timescale 1ns / 1ps
`include "keyboard_scan_code_processor_defines.svh"
module keyboard_scan_code_processor (
  input  logic                             clk,
  input  logic                             rst_n,
  ksc_in_if.sink                           in_ch,
  ksc_out_if.source                        out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ksc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);
  import ksc_pkg::*;

  logic        window_sel;
  logic [7:0]  repeat_window_r;
  logic        cfg_wr;
  logic        in_fire;
  logic        out_fire;
  ksc_item_t   item;
  ksc_result_t core_res;
  ksc_result_t out_r;
  ksc_result_t skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign window_sel = (cfg_paddr[CFG_ADDR_W-1:2] == CFG_IDX_REPEAT_WINDOW);
  assign cfg_prdata = window_sel ? {24'd0, repeat_window_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_window_r <= REPEAT_WINDOW_RST;
    end else if (cfg_wr && window_sel) begin
      repeat_window_r <= cfg_pwdata[7:0];
    end
  end

  // input transaction
  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  assign item.func            = in_ch.func;
  assign item.key_byte        = in_ch.key_byte;
  assign item.tick_now        = in_ch.tick_now;
  assign item.expecting_reply = in_ch.expecting_reply;

  ksc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_accept   (in_fire),
    .item          (item),
    .repeat_window (repeat_window_r),
    .result        (core_res)
  );

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_r <= core_res;
      end else begin
        skid_r <= core_res;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.result_kind     = out_r.result_kind;
  assign out_ch.reply_is_resend = out_r.reply_is_resend;
  assign out_ch.key_accepted    = out_r.key_accepted;
  assign out_ch.key_dropped     = out_r.key_dropped;
  assign out_ch.scan_code       = out_r.scan_code;
  assign out_ch.ascii_code      = out_r.ascii_code;
  assign out_ch.modifier_flags  = out_r.modifier_flags;
  assign out_ch.led_mask        = out_r.led_mask;
  assign out_ch.queue_count     = out_r.queue_count;

  // checks
  `KSC_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r)
  `KSC_ASSERT_NEXT(a_accept_fills_out, in_fire, out_valid_r)
  `KSC_ASSERT_NEXT(a_stall_holds_out, out_valid_r && !out_ch.ready, out_valid_r && $stable(out_r))

endmodule

/* bench/tb_top.sv */
// testbench for the keyboard scan code processor: stimulus, key decoder and result checks
`timescale 1ns / 1ps
module tb_top;
  import ksc_pkg::*;

  localparam int GLYPH_COUNT = 58;
  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = {CFG_IDX_REPEAT_WINDOW, 2'b00};
  localparam int PHASE_ITEMS = 245;

  typedef enum int {MODE_TYPING, MODE_DRAINING, MODE_MIXED} traffic_t;

  typedef struct {
    ksc_item_t   item;
    bit          typed;
    ksc_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  ksc_in_if  in_ch ();
  ksc_out_if out_ch ();

  keyboard_scan_code_processor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // set 1 glyphs, unshifted and shifted
  logic [6:0] plain_glyph [GLYPH_COUNT] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
    7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20
  };
  logic [6:0] shift_glyph [GLYPH_COUNT] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
    7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20
  };

  // decoder state, mirrors the block after reset
  logic [7:0]  window_reg    = REPEAT_WINDOW_RST;
  logic [5:0]  mods          = '0;
  logic        prefix_armed  = 1'b0;
  logic [6:0]  last_key_code = '0;
  logic [31:0] last_key_tick = '0;
  logic [6:0]  key_ring [QUEUE_DEPTH];
  qidx_t       head_q        = '0;
  qidx_t       tail_q        = '0;

  ksc_result_t key_results_due [$];
  stim_row_t   stim_table [$];

  // stimulus shaping
  int          burst_left   = 0;
  int          mode_left    = 0;
  traffic_t    traffic      = MODE_MIXED;
  logic [31:0] tick_count   = '0;
  int          hold_request = 0;

  // bookkeeping
  int mismatch_count = 0;
  int results_seen   = 0;
  int items_sent     = 0;
  int keys_queued    = 0;
  int keys_dropped   = 0;
  int keys_popped    = 0;
  int empty_pops     = 0;
  int replies_seen   = 0;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ascii of a scan code under current shift and caps
  function automatic logic [6:0] translate(logic [6:0] sc);
    logic [6:0] lo;
    logic       up;
    if (sc >= 7'(GLYPH_COUNT)) return 7'h00;
    lo = plain_glyph[sc[5:0]];
    up = mods[MOD_SHIFT];
    if (lo >= 7'h61 && lo <= 7'h7A) up = mods[MOD_SHIFT] ^ mods[MOD_CAPS];
    return up ? shift_glyph[sc[5:0]] : lo;
  endfunction

  // held modifiers follow make and break, locks toggle on make
  function automatic void update_modifiers(logic [7:0] code);
    logic brk;
    brk = code[7];
    case (code[6:0]) inside
      SC_LSHIFT, SC_RSHIFT: mods[MOD_SHIFT] = !brk;
      SC_CTRL: mods[MOD_CTRL] = !brk;
      SC_ALT: mods[MOD_ALT] = !brk;
      SC_CAPS: if (!brk) mods[MOD_CAPS] = !mods[MOD_CAPS];
      SC_NUM: if (!brk) mods[MOD_NUM] = !mods[MOD_NUM];
      SC_SCROLL: if (!brk) mods[MOD_SCROLL] = !mods[MOD_SCROLL];
      default: ;
    endcase
  endfunction

  // expected result of one accepted transaction, advances decoder state
  function automatic ksc_result_t decode_transaction(ksc_item_t it);
    ksc_result_t r;
    logic [7:0]  code;
    logic [31:0] elapsed;
    r = '0;
    r.result_kind = KIND_BYTE;
    code = it.key_byte;
    if (it.func == FUNC_POP) begin
      if (head_q == tail_q) begin
        r.result_kind = KIND_EMPTY;
      end else begin
        r.result_kind = KIND_POP;
        r.scan_code = key_ring[head_q];
        head_q = head_q + 1'b1;
        r.ascii_code = translate(r.scan_code);
      end
    end else if (it.expecting_reply && (code == CODE_ACK || code == CODE_RESEND)) begin
      r.result_kind = KIND_REPLY;
      r.reply_is_resend = (code == CODE_RESEND);
    end else if (code == CODE_PFX_E0 || code == CODE_PFX_E1) begin
      prefix_armed = 1'b1;
    end else begin
      update_modifiers(code);
      if (!code[7] && !prefix_armed) begin
        elapsed = it.tick_now - last_key_tick;
        // autorepeat filter, records the key even when the ring is full
        if (!(code[6:0] == last_key_code && elapsed <= {24'd0, window_reg})) begin
          last_key_code = code[6:0];
          last_key_tick = it.tick_now;
          if (qidx_t'(tail_q + 1'b1) != head_q) begin
            key_ring[tail_q] = code[6:0];
            tail_q = tail_q + 1'b1;
            r.key_accepted = 1'b1;
          end else begin
            r.key_dropped = 1'b1;
          end
        end
      end
      prefix_armed = 1'b0;
    end
    r.modifier_flags = mods;
    r.led_mask = {mods[MOD_CAPS], mods[MOD_NUM], mods[MOD_SCROLL]};
    r.queue_count = 6'(tail_q - head_q);
    return r;
  endfunction

  // random transaction, key traffic mixed with pops whose share depends on the mode
  function automatic ksc_item_t random_transaction();
    ksc_item_t   it;
    int unsigned pick;
    int unsigned pop_share;
    logic [6:0]  sc;
    if (mode_left == 0) begin
      traffic = traffic_t'($urandom_range(0, 2));
      mode_left = $urandom_range(30, 150);
    end
    mode_left--;
    case (traffic)
      MODE_TYPING: pop_share = 8;
      MODE_DRAINING: pop_share = 65;
      default: pop_share = 35;
    endcase
    tick_count += 32'($urandom_range(0, 3));
    if ($urandom_range(0, 49) == 0) tick_count = $urandom();
    it.func = FUNC_BYTE;
    it.key_byte = 8'($urandom_range(0, 255));
    it.tick_now = tick_count;
    it.expecting_reply = ($urandom_range(0, 7) == 0);
    pick = $urandom_range(0, 99);
    if (pick < pop_share) begin
      it.func = FUNC_POP;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        it.key_byte = {1'b0, 7'($urandom_range(0, 127))};
      end else if (pick < 57) begin
        // repeat of the last key, often right at the window edge
        it.key_byte = {1'b0, last_key_code};
        if ($urandom_range(0, 1) == 1)
          it.tick_now = last_key_tick + {24'd0, window_reg} - 32'd1
                        + 32'($urandom_range(0, 2));
      end else if (pick < 70) begin
        case ($urandom_range(0, 6))
          0: sc = SC_LSHIFT;
          1: sc = SC_RSHIFT;
          2: sc = SC_CTRL;
          3: sc = SC_ALT;
          4: sc = SC_CAPS;
          5: sc = SC_NUM;
          default: sc = SC_SCROLL;
        endcase
        it.key_byte = {1'($urandom_range(0, 1)), sc};
      end else if (pick < 80) begin
        it.key_byte[7] = 1'b1;
      end else if (pick < 87) begin
        it.key_byte = ($urandom_range(0, 1) == 1) ? CODE_PFX_E0 : CODE_PFX_E1;
      end else if (pick < 94) begin
        it.key_byte = ($urandom_range(0, 1) == 1) ? CODE_ACK : CODE_RESEND;
        it.expecting_reply = ($urandom_range(0, 3) != 0);
      end
    end
    return it;
  endfunction

  // directed table entries
  task automatic add_step(logic f, logic [7:0] b, logic [31:0] t, logic e);
    stim_row_t r;
    r.item = {f, b, t, e};
    r.typed = 1'b0;
    r.want = '0;
    stim_table.push_back(r);
  endtask

  task automatic typed_result(kind_t k, logic rs, logic acc, logic drp, logic [6:0] sc,
                              logic [6:0] asc, logic [5:0] mf, logic [2:0] led,
                              logic [5:0] qc);
    stim_row_t r;
    r = stim_table.pop_back();
    r.typed = 1'b1;
    r.want = {k, rs, acc, drp, sc, asc, mf, led, qc};
    stim_table.push_back(r);
  endtask

  // offer one transaction in bursts with random gaps, record what it must produce
  task automatic send_item(input ksc_item_t it, input bit typed, input ksc_result_t want);
    ksc_result_t predicted;
    int          gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.func            <= it.func;
    in_ch.key_byte        <= it.key_byte;
    in_ch.tick_now        <= it.tick_now;
    in_ch.expecting_reply <= it.expecting_reply;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = decode_transaction(it);
    key_results_due.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (key_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one apb transfer: setup then access
  task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= WINDOW_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic log_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at result %0d: expected 0x%0h, got 0x%0h",
               what, results_seen, want, got);
  endtask

  // register read must match the window in use
  task automatic check_window();
    logic [31:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd !== {24'd0, window_reg}) log_mismatch("repeat_window read", 32'(window_reg), rd);
  endtask

  task automatic program_window(input logic [7:0] v);
    logic [31:0] rd;
    apb_xfer(1'b1, {24'd0, v}, rd);
    window_reg = v;
    check_window();
  endtask

  task automatic compare_result(ksc_result_t want, ksc_result_t got);
    if (got.result_kind !== want.result_kind)
      log_mismatch("result_kind", 32'(want.result_kind), 32'(got.result_kind));
    if (got.reply_is_resend !== want.reply_is_resend)
      log_mismatch("reply_is_resend", 32'(want.reply_is_resend), 32'(got.reply_is_resend));
    if (got.key_accepted !== want.key_accepted)
      log_mismatch("key_accepted", 32'(want.key_accepted), 32'(got.key_accepted));
    if (got.key_dropped !== want.key_dropped)
      log_mismatch("key_dropped", 32'(want.key_dropped), 32'(got.key_dropped));
    if (got.scan_code !== want.scan_code)
      log_mismatch("scan_code", 32'(want.scan_code), 32'(got.scan_code));
    if (got.ascii_code !== want.ascii_code)
      log_mismatch("ascii_code", 32'(want.ascii_code), 32'(got.ascii_code));
    if (got.modifier_flags !== want.modifier_flags)
      log_mismatch("modifier_flags", 32'(want.modifier_flags), 32'(got.modifier_flags));
    if (got.led_mask !== want.led_mask)
      log_mismatch("led_mask", 32'(want.led_mask), 32'(got.led_mask));
    if (got.queue_count !== want.queue_count)
      log_mismatch("queue_count", 32'(want.queue_count), 32'(got.queue_count));
  endtask

  // result monitor
  ksc_result_t seen_result;
  ksc_result_t due_result;
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen_result = {out_ch.result_kind, out_ch.reply_is_resend, out_ch.key_accepted,
                     out_ch.key_dropped, out_ch.scan_code, out_ch.ascii_code,
                     out_ch.modifier_flags, out_ch.led_mask, out_ch.queue_count};
      results_seen++;
      if (key_results_due.size() == 0) begin
        log_mismatch("unexpected result, kind", '0, 32'(seen_result.result_kind));
      end else begin
        due_result = key_results_due.pop_front();
        compare_result(due_result, seen_result);
        if (due_result.key_accepted) keys_queued++;
        if (due_result.key_dropped) keys_dropped++;
        if (due_result.result_kind == KIND_POP) keys_popped++;
        if (due_result.result_kind == KIND_EMPTY) empty_pops++;
        if (due_result.result_kind == KIND_REPLY) replies_seen++;
      end
    end
  end

  // receiver: changing stall styles, plus long hold-offs on request
  initial begin
    int style;
    int style_left;
    int hold_left;
    style = 0;
    style_left = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 2);
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // main sequence
  initial begin
    in_ch.valid           = 1'b0;
    in_ch.func            = FUNC_BYTE;
    in_ch.key_byte        = '0;
    in_ch.tick_now        = '0;
    in_ch.expecting_reply = 1'b0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;
    rst_n                 = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // window comes out of reset at its default
    check_window();

    // directed transactions
    add_step(FUNC_POP, 8'h00, 32'd0, 1'b0);
    typed_result(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(FUNC_BYTE, CODE_ACK, 32'd0, 1'b1);
    typed_result(KIND_REPLY, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(FUNC_BYTE, CODE_RESEND, 32'd0, 1'b1);
    typed_result(KIND_REPLY, 1, 0, 0, 0, 0, 0, 0, 0);
    // ack with no reply pending is just a break code
    add_step(FUNC_BYTE, CODE_ACK, 32'd0, 1'b0);
    typed_result(KIND_BYTE, 0, 0, 0, 0, 0, 0, 0, 0);
    // prefixed make and break queue nothing
    add_step(FUNC_BYTE, CODE_PFX_E0, 32'd0, 1'b0);
    typed_result(KIND_BYTE, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(FUNC_BYTE, 8'h1E, 32'd0, 1'b0);
    typed_result(KIND_BYTE, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(FUNC_BYTE, CODE_PFX_E1, 32'd0, 1'b0);
    typed_result(KIND_BYTE, 0, 0, 0, 0, 0, 0, 0, 0);
    add_step(FUNC_BYTE, {1'b1, SC_LSHIFT}, 32'd0, 1'b0);
    typed_result(KIND_BYTE, 0, 0, 0, 0, 0, 0, 0, 0);
    // autorepeat: inside the window dropped, past it accepted
    add_step(FUNC_BYTE, 8'h1E, 32'd100, 1'b1);
    typed_result(KIND_BYTE, 0, 1, 0, 0, 0, 0, 0, 1);
    add_step(FUNC_BYTE, 8'h1E, 32'd101, 1'b0);
    typed_result(KIND_BYTE, 0, 0, 0, 0, 0, 0, 0, 1);
    add_step(FUNC_BYTE, 8'h1E, 32'd102, 1'b0);
    add_step(FUNC_BYTE, {1'b0, SC_LSHIFT}, 32'd200, 1'b0);
    add_step(FUNC_POP, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    // locks and held modifiers
    add_step(FUNC_BYTE, {1'b0, SC_CAPS}, 32'd300, 1'b0);
    add_step(FUNC_BYTE, {1'b0, SC_NUM}, 32'd301, 1'b0);
    add_step(FUNC_BYTE, {1'b0, SC_SCROLL}, 32'd302, 1'b0);
    add_step(FUNC_BYTE, {1'b0, SC_CTRL}, 32'd303, 1'b0);
    add_step(FUNC_BYTE, {1'b0, SC_ALT}, 32'd304, 1'b0);
    // tick wraps between two identical makes
    add_step(FUNC_BYTE, 8'h10, 32'hFFFF_FFFF, 1'b0);
    add_step(FUNC_BYTE, 8'h10, 32'h0000_0000, 1'b0);
    // extreme bytes
    add_step(FUNC_BYTE, 8'h00, 32'd7, 1'b0);
    add_step(FUNC_BYTE, 8'h7F, 32'd9, 1'b0);
    add_step(FUNC_BYTE, 8'hFF, 32'd9, 1'b0);
    add_step(FUNC_BYTE, {1'b1, SC_CTRL}, 32'd10, 1'b0);
    add_step(FUNC_POP, 8'h00, 32'd11, 1'b0);

    foreach (stim_table[i]) send_item(stim_table[i].item, stim_table[i].typed,
                                      stim_table[i].want);

    // random traffic over several window settings
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain_results();
        case (ph)
          1: program_window(8'd0);
          2: program_window(8'd255);
          3: program_window(8'($urandom_range(2, 254)));
          default: program_window(8'($urandom_range(0, 7)));
        endcase
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long receiver hold-off while transactions keep coming
        if ((ph == 2 || ph == 4) && i == 100) hold_request = $urandom_range(150, 300);
        send_item(random_transaction(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (16) @(posedge clk);

    $display("run covered %0d transactions over five repeat-window settings", items_sent);
    $display("keys queued %0d, dropped on full queue %0d, popped %0d, empty pops %0d, replies %0d",
             keys_queued, keys_dropped, keys_popped, empty_pops, replies_seen);
    if (mismatch_count == 0 && key_results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
